### rtl/core/rcmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcmp_pkg
// Types, chunk ids and lookup helpers shared by the sound-bank chunk map
// parser modules.
// ----------------------------------------------------------------------------
package rcmp_pkg;

  // one input request: a chunk data byte and the restart marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  // one result request
  typedef struct packed {
    logic        entry_valid;
    logic [4:0]  kind;
    logic [31:0] head_offset;
    logic [31:0] chunk_size;
    logic        done_res;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // walk phase
  typedef enum logic [2:0] {
    PH_FORM  = 3'd0,
    PH_LHEAD = 3'd1,
    PH_LFORM = 3'd2,
    PH_SHEAD = 3'd3,
    PH_SKIP  = 3'd4
  } phase_e;

  // done status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_BEYOND  = 3'd2,
    ST_ODD     = 3'd3,
    ST_FORM    = 3'd4,
    ST_NOTLIST = 3'd5
  } status_e;

  // what one byte produces: an optional entry then an optional done
  typedef struct packed {
    logic        ent_v;
    logic [4:0]  kind;
    logic [31:0] head_offset;
    logic [31:0] chunk_size;
    logic        done_v;
    status_e     status;
  } step_res_t;

  localparam int unsigned HeadLen  = 8;
  localparam int unsigned NumKinds = 22;

  localparam logic [31:0] FccSfbk = 32'h7366626b;
  localparam logic [31:0] FccList = 32'h4c495354;
  localparam logic [31:0] FccInfo = 32'h494e464f;
  localparam logic [31:0] FccSdta = 32'h73647461;
  localparam logic [31:0] FccPdta = 32'h70647461;

  // known sub-chunk ids, indexed by kind
  localparam logic [31:0] KnownIds [NumKinds] = '{
    32'h6966696c, 32'h69736e67, 32'h494e414d, 32'h69726f6d, 32'h69766572,
    32'h49435244, 32'h49454e47, 32'h49505244, 32'h49434f50, 32'h49434d54,
    32'h49534654, 32'h736d706c, 32'h736d3234, 32'h70686472, 32'h70626167,
    32'h706d6f64, 32'h7067656e, 32'h696e7374, 32'h69626167, 32'h696d6f64,
    32'h6967656e, 32'h73686472
  };

  // expected form type of list number li
  function automatic logic [31:0] list_form(logic [1:0] li);
    logic [31:0] f;
    case (li)
      2'd0:    f = FccInfo;
      2'd1:    f = FccSdta;
      default: f = FccPdta;
    endcase
    return f;
  endfunction

  // id to kind within the range of list li, returns {hit, kind}
  function automatic logic [5:0] kind_lookup(logic [31:0] id, logic [1:0] li);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [5:0] r;
    case (li)
      2'd0: begin
        lo = 5'd0;
        hi = 5'd10;
      end
      2'd1: begin
        lo = 5'd11;
        hi = 5'd12;
      end
      default: begin
        lo = 5'd13;
        hi = 5'd21;
      end
    endcase
    r = '0;
    for (int k = 0; k < NumKinds; k++) begin
      if (KnownIds[k] == id && 5'(k) >= lo && 5'(k) <= hi) begin
        r = {1'b1, 5'(k)};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/rcmp_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcmp_walk
// Chunk walk state and the per-byte step: head collection, checks, kind
// lookup and the results of one byte.
// ----------------------------------------------------------------------------
module rcmp_walk (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire rcmp_pkg::in_item_t    item_i,
  input  wire logic [31:0]           riff_size_i,
  output rcmp_pkg::step_res_t        res_o
);
  import rcmp_pkg::*;

  logic [31:0] off_q, off_d;
  logic [55:0] shift_q, shift_d;
  phase_e      phase_q, phase_d;
  logic [1:0]  ln_q, ln_d;
  logic [32:0] le_q, le_d;
  logic [32:0] se_q, se_d;
  logic        fin_q, fin_d;

  // state seen by this byte, after a restart marker
  logic [31:0] e_off;
  logic [55:0] e_shift;
  phase_e      e_phase;
  logic [1:0]  e_ln;
  logic [32:0] e_le;
  logic [32:0] e_se;
  logic        e_fin;

  logic [32:0] q;
  logic [63:0] full;
  logic [31:0] word;
  logic [31:0] id;
  logic [31:0] size;
  logic [33:0] d_hd;
  logic        hd8, hd4;
  logic [33:0] h_end;
  logic        beyond_riff, beyond_list;
  logic [33:0] q8;
  logic [1:0]  li;
  logic [5:0]  klu;
  logic        riff_short, fs_trunc;
  logic        c_past, c_last, c_trunc;
  logic [32:0] c_limit;
  logic        cont_done, cont_inc;
  status_e     cont_status;
  phase_e      cont_phase;
  logic [33:0] q_plus_size;

  // restart marker overrides the stored walk
  always_comb begin
    if (item_i.first_byte) begin
      e_off   = '0;
      e_shift = '0;
      e_phase = PH_FORM;
      e_ln    = '0;
      e_le    = '0;
      e_se    = '0;
      e_fin   = 1'b0;
    end else begin
      e_off   = off_q;
      e_shift = shift_q;
      e_phase = phase_q;
      e_ln    = ln_q;
      e_le    = le_q;
      e_se    = se_q;
      e_fin   = fin_q;
    end
  end

  // shared decode of the current byte
  always_comb begin
    q           = {1'b0, e_off} + 33'd1;
    full        = {e_shift, item_i.data_byte};
    word        = full[31:0];
    id          = full[63:32];
    size        = {full[7:0], full[15:8], full[23:16], full[31:24]};
    d_hd        = {1'b0, q} - {1'b0, e_se};
    hd8         = d_hd[33] | (|d_hd[32:3]);
    hd4         = d_hd[33] | (|d_hd[32:2]);
    h_end       = {1'b0, e_se} + 34'(HeadLen) + {2'b00, size};
    beyond_riff = h_end > {2'b00, riff_size_i};
    beyond_list = h_end > {1'b0, e_le};
    q8          = {1'b0, q} + 34'(HeadLen);
    q_plus_size = {1'b0, q} + {2'b00, size};
    li          = (e_ln > 2'd2) ? 2'd2 : e_ln;
    klu         = kind_lookup(id, li);
    riff_short  = riff_size_i < 32'd4;
    fs_trunc    = riff_size_i < 32'(4 + HeadLen);
    // next list or next sub-chunk head
    c_past      = q >= e_le;
    c_last      = e_ln >= 2'd2;
    c_limit     = c_past ? {1'b0, riff_size_i} : e_le;
    c_trunc     = q8 > {1'b0, c_limit};
    cont_done   = c_past ? (c_last | c_trunc) : c_trunc;
    cont_status = (c_past && c_last) ? ST_OK : ST_TRUNC;
    cont_phase  = c_past ? PH_LHEAD : PH_SHEAD;
    cont_inc    = c_past & ~c_last;
  end

  // next walk state
  always_comb begin
    off_d   = e_off + 32'd1;
    shift_d = e_shift;
    phase_d = e_phase;
    ln_d    = e_ln;
    le_d    = e_le;
    se_d    = e_se;
    fin_d   = e_fin;
    if (!e_fin) begin
      shift_d = full[55:0];
      case (e_phase)
        PH_FORM: begin
          if (riff_short) begin
            fin_d = 1'b1;
          end else if (q >= 33'd4) begin
            if (word != FccSfbk || fs_trunc) begin
              fin_d = 1'b1;
            end else begin
              phase_d = PH_LHEAD;
              se_d    = 33'd4;
              shift_d = '0;
            end
          end
        end
        PH_LHEAD: begin
          if (hd8) begin
            if (beyond_riff || size[0] || id != FccList || size < 32'd4) begin
              fin_d = 1'b1;
            end else begin
              le_d    = q_plus_size[32:0];
              se_d    = q;
              shift_d = '0;
              phase_d = PH_LFORM;
            end
          end
        end
        PH_LFORM: begin
          if (hd4) begin
            if (word != list_form(li)) begin
              fin_d = 1'b1;
            end else begin
              if (cont_inc) ln_d = e_ln + 2'd1;
              if (cont_done) begin
                fin_d = 1'b1;
              end else begin
                phase_d = cont_phase;
                se_d    = q;
                shift_d = '0;
              end
            end
          end
        end
        PH_SHEAD: begin
          if (hd8) begin
            if (beyond_list || size[0]) begin
              fin_d = 1'b1;
            end else if (size == 32'd0) begin
              if (cont_inc) ln_d = e_ln + 2'd1;
              if (cont_done) begin
                fin_d = 1'b1;
              end else begin
                phase_d = cont_phase;
                se_d    = q;
                shift_d = '0;
              end
            end else begin
              se_d    = q_plus_size[32:0];
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (q >= e_se) begin
            if (cont_inc) ln_d = e_ln + 2'd1;
            if (cont_done) begin
              fin_d = 1'b1;
            end else begin
              phase_d = cont_phase;
              se_d    = q;
              shift_d = '0;
            end
          end
        end
        default: begin
          fin_d = 1'b1;
        end
      endcase
    end
  end

  // results of this byte
  always_comb begin
    res_o             = '0;
    res_o.status      = ST_OK;
    res_o.kind        = klu[4:0];
    res_o.head_offset = e_se[31:0];
    res_o.chunk_size  = size;
    if (!e_fin) begin
      case (e_phase)
        PH_FORM: begin
          if (riff_short) begin
            res_o.done_v = 1'b1;
            res_o.status = ST_TRUNC;
          end else if (q >= 33'd4) begin
            if (word != FccSfbk) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_FORM;
            end else if (fs_trunc) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_TRUNC;
            end
          end
        end
        PH_LHEAD: begin
          if (hd8) begin
            if (beyond_riff) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_BEYOND;
            end else if (size[0]) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_ODD;
            end else if (id != FccList) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_NOTLIST;
            end else if (size < 32'd4) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_TRUNC;
            end
          end
        end
        PH_LFORM: begin
          if (hd4) begin
            if (word != list_form(li)) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_FORM;
            end else if (cont_done) begin
              res_o.done_v = 1'b1;
              res_o.status = cont_status;
            end
          end
        end
        PH_SHEAD: begin
          if (hd8) begin
            if (beyond_list) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_BEYOND;
            end else if (size[0]) begin
              res_o.done_v = 1'b1;
              res_o.status = ST_ODD;
            end else begin
              res_o.ent_v = klu[5];
              if (size == 32'd0 && cont_done) begin
                res_o.done_v = 1'b1;
                res_o.status = cont_status;
              end
            end
          end
        end
        PH_SKIP: begin
          if (q >= e_se && cont_done) begin
            res_o.done_v = 1'b1;
            res_o.status = cont_status;
          end
        end
        default: begin
          res_o.done_v = 1'b1;
          res_o.status = ST_TRUNC;
        end
      endcase
    end
  end

  // walk state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      shift_q <= '0;
      phase_q <= PH_FORM;
      ln_q    <= '0;
      le_q    <= '0;
      se_q    <= '0;
      fin_q   <= 1'b0;
    end else if (step_i) begin
      off_q   <= off_d;
      shift_q <= shift_d;
      phase_q <= phase_d;
      ln_q    <= ln_d;
      le_q    <= le_d;
      se_q    <= se_d;
      fin_q   <= fin_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/rcmp_res_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcmp_res_buf
// Result register for the results of one byte; hands them out one request
// at a time, entry first, with last on the final one.
// ----------------------------------------------------------------------------
module rcmp_res_buf (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire rcmp_pkg::step_res_t   res_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rcmp_pkg::out_item_t        out_data_o
);
  import rcmp_pkg::*;

  logic      vld_q, vld_d;
  logic      two_q, two_d;
  logic      idx_q, idx_d;
  out_item_t r0_q, r1_q;
  out_item_t ent_item, done_item;
  logic      pop, pop_last;

  // result requests built from the step
  always_comb begin
    ent_item             = '0;
    ent_item.entry_valid = 1'b1;
    ent_item.kind        = res_i.kind;
    ent_item.head_offset = res_i.head_offset;
    ent_item.chunk_size  = res_i.chunk_size;
    ent_item.last        = ~res_i.done_v;
    done_item            = '0;
    done_item.done_res   = 1'b1;
    done_item.status     = res_i.status;
    done_item.last       = 1'b1;
  end

  // drain and refill control
  always_comb begin
    pop      = vld_q & out_ready_i;
    pop_last = pop & (~two_q | idx_q);
    ready_o  = ~vld_q | pop_last;
    vld_d    = vld_q;
    two_d    = two_q;
    idx_d    = idx_q;
    if (pop) begin
      if (pop_last) vld_d = 1'b0;
      else idx_d = 1'b1;
    end
    if (load_i && (res_i.ent_v || res_i.done_v)) begin
      vld_d = 1'b1;
      two_d = res_i.ent_v & res_i.done_v;
      idx_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      two_q <= 1'b0;
      idx_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      two_q <= two_d;
      idx_q <= idx_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r0_q <= res_i.ent_v ? ent_item : done_item;
      r1_q <= done_item;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = idx_q ? r1_q : r0_q;

endmodule
`default_nettype wire

### rtl/core/riff_chunk_map_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riff_chunk_map_parser_top
// Sound-bank RIFF chunk map parser: walks the sfbk form and its INFO, sdta
// and pdta lists and reports each known sub-chunk and a final status.
// ----------------------------------------------------------------------------
// Feed one chunk data byte per request, first_byte high on offset zero of
// each file. A byte is taken into an input register and then walked into a
// result register, one byte per cycle sustained while that register can take
// the step; it hands the results out one per cycle while the receiver is
// ready, so the parser stalls only while results wait there. Most bytes cause
// no result; one that completes a zero-size sub-chunk at the end of the walk
// yields a done result, after an entry if its id is known. riff_size resets
// to 4; the user must write it only while idle, the block does not enforce it.
module riff_chunk_map_parser_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire rcmp_pkg::in_item_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rcmp_pkg::out_item_t        out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [31:0]           cfg_wdata_i
);
  import rcmp_pkg::*;

  logic        in_vld_q;
  in_item_t    in_data_q;
  logic [31:0] riff_size_q;
  logic        buf_ready;
  logic        step_go;
  step_res_t   step_res;

  // input register advances when the result register can take the step
  assign step_go    = in_vld_q & buf_ready;
  assign in_ready_o = ~in_vld_q | step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      riff_size_q <= 32'd4;
    end else if (cfg_we_i) begin
      riff_size_q <= cfg_wdata_i;
    end
  end

  rcmp_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_go),
    .item_i      (in_data_q),
    .riff_size_i (riff_size_q),
    .res_o       (step_res)
  );

  rcmp_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_go),
    .res_i       (step_res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a done result always closes the results of its byte
  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.last)
    else $error("done result without last");

  // an entry result carries no done flag and a zero status
  a_entry_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_valid |->
      !out_data_o.done_res && out_data_o.status == ST_OK)
    else $error("entry result with done or status set");

  // input stalls only while results are waiting
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the sound-bank chunk map parser byte by byte. A behavioral walker
// follows the sfbk form and its three lists and queues the entry and done
// results that every accepted byte should cause. Directed files cover the
// reset size, every kind and every fault status; random banks follow, mostly
// well formed, some damaged, with bursty input, a stalling receiver and one
// long output hold-off that backs the parser up.
// ----------------------------------------------------------------------------
module testbench;
  import rcmp_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int RandomBytes = 100;
  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 400;

  localparam logic [63:0] HeadBytes = 64'd8;
  localparam logic [31:0] FormSfbk  = "sfbk";
  localparam logic [31:0] ListTag   = "LIST";
  localparam logic [31:0] ListForms [3] = '{"INFO", "sdta", "pdta"};
  localparam logic [31:0] SubIds [22] = '{
    "ifil", "isng", "INAM", "irom", "iver", "ICRD", "IENG", "IPRD", "ICOP",
    "ICMT", "ISFT", "smpl", "sm24", "phdr", "pbag", "pmod", "pgen", "inst",
    "ibag", "imod", "igen", "shdr"
  };
  localparam int unsigned KindLo [3] = '{0, 11, 13};
  localparam int unsigned KindHi [3] = '{10, 12, 21};

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_data;

  riff_chunk_map_parser_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // walker state
  logic [31:0] bank_size;
  logic [31:0] walk_pos;
  logic [55:0] head_bytes;
  phase_e      walk_ph;
  logic [1:0]  list_idx;
  logic [63:0] list_stop;
  logic [63:0] seg_end;
  logic        walk_done;

  out_item_t   byte_results [$];
  out_item_t   pending_results [$];
  logic [7:0]  file_bytes [$];

  int          bad_count    = 0;
  int          bytes_sent   = 0;
  int          cycle_count  = 0;
  int          burst_left   = 0;
  bit          gaps_on      = 1'b1;
  bit          hold_request = 1'b0;
  int          hold_left    = 0;
  int          mode_left    = 0;
  int          rx_tick      = 0;
  rx_mode_e    rx_mode      = RX_OPEN;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[riff_chunk_map_parser_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- walker

  task automatic clear_walk();
    walk_pos   = '0;
    head_bytes = '0;
    walk_ph    = PH_FORM;
    list_idx   = '0;
    list_stop  = '0;
    seg_end    = '0;
    walk_done  = 1'b0;
  endtask

  task automatic note_done(status_e st);
    out_item_t r;
    r          = '0;
    r.done_res = 1'b1;
    r.status   = st;
    byte_results.push_back(r);
    walk_done  = 1'b1;
  endtask

  // arm collection of an 8-byte head, or fail if it cannot fit
  task automatic open_head(logic [63:0] pos, logic [63:0] limit, phase_e ph);
    if (pos + HeadBytes > limit) begin
      note_done(ST_TRUNC);
    end else begin
      walk_ph    = ph;
      seg_end    = pos;
      head_bytes = '0;
    end
  endtask

  // after a list form or a sub-chunk: next sub-chunk, next list or finish
  task automatic next_list(logic [63:0] pos);
    if (pos >= list_stop) begin
      if (list_idx >= 2'd2) begin
        note_done(ST_OK);
      end else begin
        list_idx = list_idx + 2'd1;
        open_head(pos, {32'd0, bank_size}, PH_LHEAD);
      end
    end else begin
      open_head(pos, list_stop, PH_SHEAD);
    end
  endtask

  // expected results of one accepted byte
  task automatic walk_byte(logic [7:0] b, logic fb);
    logic [63:0] q;
    logic [63:0] full;
    logic [31:0] id;
    logic [31:0] sz;
    logic        hit;
    out_item_t   ent;
    if (fb) clear_walk();
    q        = {32'd0, walk_pos} + 64'd1;
    walk_pos = walk_pos + 32'd1;
    if (!walk_done) begin
      full       = {head_bytes, b};
      head_bytes = full[55:0];
      id         = full[63:32];
      sz         = {full[7:0], full[15:8], full[23:16], full[31:24]};
      hit        = 1'b0;
      case (walk_ph)
        PH_FORM: begin
          if (bank_size < 32'd4) begin
            note_done(ST_TRUNC);
          end else if (q >= 64'd4) begin
            if (full[31:0] != FormSfbk) note_done(ST_FORM);
            else open_head(64'd4, {32'd0, bank_size}, PH_LHEAD);
          end
        end
        PH_LHEAD: begin
          if (q - seg_end >= HeadBytes) begin
            if (seg_end + HeadBytes + sz > {32'd0, bank_size}) begin
              note_done(ST_BEYOND);
            end else if (sz[0]) begin
              note_done(ST_ODD);
            end else if (id != ListTag) begin
              note_done(ST_NOTLIST);
            end else if (sz < 32'd4) begin
              note_done(ST_TRUNC);
            end else begin
              list_stop  = q + sz;
              seg_end    = q;
              head_bytes = '0;
              walk_ph    = PH_LFORM;
            end
          end
        end
        PH_LFORM: begin
          if (q - seg_end >= 64'd4) begin
            if (full[31:0] != ListForms[list_idx]) note_done(ST_FORM);
            else next_list(q);
          end
        end
        PH_SHEAD: begin
          if (q - seg_end >= HeadBytes) begin
            if (seg_end + HeadBytes + sz > list_stop) begin
              note_done(ST_BEYOND);
            end else if (sz[0]) begin
              note_done(ST_ODD);
            end else begin
              // only ids of the current list are reported
              for (int k = KindLo[list_idx]; k <= KindHi[list_idx]; k++) begin
                if (!hit && SubIds[k] == id) begin
                  hit             = 1'b1;
                  ent             = '0;
                  ent.entry_valid = 1'b1;
                  ent.kind        = 5'(k);
                  ent.head_offset = seg_end[31:0];
                  ent.chunk_size  = sz;
                  byte_results.push_back(ent);
                end
              end
              if (sz == 32'd0) begin
                next_list(q);
              end else begin
                seg_end = q + sz;
                walk_ph = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (q >= seg_end) next_list(q);
        end
        default: begin
          note_done(ST_TRUNC);
        end
      endcase
      // flag the final result of this byte
      if (byte_results.size() > 0) begin
        ent      = byte_results.pop_back();
        ent.last = 1'b1;
        byte_results.push_back(ent);
        foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
        byte_results.delete();
      end
    end
  endtask

  // -------------------------------------------------------------- checking

  function automatic string res_text(out_item_t r);
    return $sformatf("ent=%0d kind=%0d off=%h size=%h done=%0d st=%0d last=%0d",
                     r.entry_valid, r.kind, r.head_offset, r.chunk_size,
                     r.done_res, r.status, r.last);
  endfunction

  // compare every result request with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (bad_count < 10) $display("unexpected result: %s", res_text(out_data));
        bad_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.entry_valid !== want.entry_valid ||
            out_data.kind !== want.kind ||
            out_data.head_offset !== want.head_offset ||
            out_data.chunk_size !== want.chunk_size ||
            out_data.done_res !== want.done_res ||
            out_data.status !== want.status ||
            out_data.last !== want.last) begin
          if (bad_count < 10) begin
            $display("result mismatch\n  exp %s\n  got %s",
                     res_text(want), res_text(out_data));
          end
          bad_count++;
        end
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- driving

  // offer one byte request, in bursts with random gaps between them
  task automatic send_req(in_item_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    walk_byte(req.data_byte, req.first_byte);
    bytes_sent++;
  endtask

  task automatic feed(int first_idx, int end_idx, bit restart);
    in_item_t req;
    for (int i = first_idx; i < end_idx; i++) begin
      req.data_byte  = file_bytes[i];
      req.first_byte = restart && (i == first_idx);
      send_req(req);
    end
  endtask

  // drop valid and wait until every expected result is out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_size(logic [31:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    bank_size = v;
  endtask

  task automatic run_file(logic [31:0] size);
    write_size(size);
    feed(0, file_bytes.size(), 1'b1);
  endtask

  // ----------------------------------------------------------- file building

  task automatic add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic add_le(logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic add_chunk(logic [31:0] id, logic [31:0] sz, int body);
    add_word(id);
    add_le(sz);
    repeat (body) file_bytes.push_back(8'($urandom));
  endtask

  task automatic new_bank();
    file_bytes.delete();
    add_word(FormSfbk);
  endtask

  task automatic open_list(logic [31:0] form, output int at);
    add_word(ListTag);
    at = file_bytes.size();
    add_le(32'd0);
    add_word(form);
  endtask

  // patch the list size once its body is known
  task automatic close_list(int at);
    logic [31:0] n;
    n = file_bytes.size() - at - 4;
    for (int i = 0; i < 4; i++) file_bytes[at + i] = n[8*i +: 8];
  endtask

  // well-formed bank with a few random sub-chunks per list
  task automatic make_bank();
    int          at;
    int          pick;
    logic [31:0] id;
    logic [31:0] sz;
    new_bank();
    for (int li = 0; li < 3; li++) begin
      open_list(ListForms[li], at);
      repeat ($urandom_range(0, 3)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) id = SubIds[$urandom_range(KindLo[li], KindHi[li])];
        else if (pick < 8) id = SubIds[$urandom_range(0, 21)];
        else id = $urandom;
        sz = 2 * $urandom_range(0, 4);
        add_chunk(id, sz, sz);
      end
      close_list(at);
    end
  endtask

  // ------------------------------------------------------------------ tests

  // reset size of 4 and no first_byte marker: walk starts anyway, head can't fit
  task automatic test_reset_size();
    new_bank();
    add_word(ListTag);
    feed(0, file_bytes.size(), 1'b0);
  endtask

  task automatic test_short_sizes();
    logic [31:0] sizes [4];
    sizes = '{32'd0, 32'd1, 32'd3, 32'd8};
    foreach (sizes[i]) begin
      new_bank();
      add_word(ListTag);
      run_file(sizes[i]);
    end
    // wrong form type
    file_bytes.delete();
    add_word("sfbx");
    add_word(ListTag);
    run_file(32'd100);
  endtask

  // every kind, unknown and misplaced ids, a duplicate, trailing bytes
  task automatic test_full_bank();
    int at;
    int len;
    new_bank();
    open_list(ListForms[0], at);
    for (int k = 0; k <= 10; k++) add_chunk(SubIds[k], 2 * (k % 3), 2 * (k % 3));
    add_chunk("xyzw", 2, 2);
    add_chunk(SubIds[11], 4, 4);
    add_chunk(SubIds[2], 0, 0);
    close_list(at);
    open_list(ListForms[1], at);
    add_chunk(SubIds[11], 6, 6);
    add_chunk(SubIds[12], 0, 0);
    close_list(at);
    open_list(ListForms[2], at);
    // zero-size final sub-chunk: entry and done from one byte
    for (int k = 13; k <= 21; k++) add_chunk(SubIds[k], (k == 21) ? 0 : 2, (k == 21) ? 0 : 2);
    close_list(at);
    len = file_bytes.size();
    repeat (5) file_bytes.push_back(8'($urandom));
    run_file(len);
  endtask

  task automatic test_list_faults();
    new_bank();
    add_chunk("LIsT", 4, 0);
    add_word(ListForms[0]);
    run_file(32'd40);
    new_bank();
    add_chunk(ListTag, 5, 0);
    add_word(ListForms[0]);
    run_file(32'd40);
    new_bank();
    add_chunk(ListTag, 100, 0);
    run_file(32'd20);
    // list too short for its form type
    new_bank();
    add_chunk(ListTag, 2, 0);
    add_word(ListForms[0]);
    run_file(32'd40);
    // lists out of order
    new_bank();
    add_chunk(ListTag, 4, 0);
    add_word(ListForms[1]);
    run_file(32'd16);
    // second list head runs past the bank
    new_bank();
    add_chunk(ListTag, 4, 0);
    add_word(ListForms[0]);
    add_word(ListTag);
    run_file(32'd20);
    // size sum above 32 bits
    new_bank();
    add_chunk(ListTag, 32'hFFFF_FFFE, 0);
    run_file(32'hFFFF_FFFF);
  endtask

  task automatic test_sub_faults();
    new_bank();
    add_chunk(ListTag, 8, 0);
    add_word(ListForms[0]);
    add_word("ifil");
    run_file(file_bytes.size());
    new_bank();
    add_chunk(ListTag, 12, 0);
    add_word(ListForms[0]);
    add_chunk(SubIds[0], 2, 0);
    run_file(file_bytes.size());
    new_bank();
    add_chunk(ListTag, 16, 0);
    add_word(ListForms[0]);
    add_chunk(SubIds[0], 3, 4);
    run_file(file_bytes.size());
    // huge list and sub-chunk sizes
    new_bank();
    add_chunk(ListTag, 32'hFFFF_FFF0, 0);
    add_word(ListForms[0]);
    add_chunk(SubIds[0], 32'hFFFF_FFE0, 6);
    run_file(32'hFFFF_FFFF);
    new_bank();
    add_chunk(ListTag, 32'hFFFF_FFF0, 0);
    add_word(ListForms[0]);
    add_chunk(SubIds[1], 32'hFFFF_FFFE, 0);
    run_file(32'hFFFF_FFFF);
  endtask

  // size written between bytes of one walk, with the parser idle
  task automatic test_size_change();
    int len;
    make_bank();
    len = file_bytes.size();
    write_size(len);
    feed(0, 24, 1'b1);
    write_size($urandom_range(24, len + 8));
    feed(24, len, 1'b0);
  endtask

  // long output hold-off while bytes keep coming
  task automatic test_backpressure();
    int at;
    new_bank();
    open_list(ListForms[0], at);
    close_list(at);
    open_list(ListForms[1], at);
    close_list(at);
    open_list(ListForms[2], at);
    repeat (12) add_chunk(SubIds[$urandom_range(13, 21)], 0, 0);
    close_list(at);
    write_size(file_bytes.size());
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    feed(0, file_bytes.size(), 1'b1);
    gaps_on      = 1'b1;
  endtask

  task automatic test_random_banks();
    int          byte_base;
    int          cut;
    logic [31:0] size;
    byte_base = bytes_sent;
    while (bytes_sent - byte_base < RandomBytes) begin
      make_bank();
      size    = file_bytes.size();
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 11))
        0: begin
          cut = $urandom_range(0, size - 1);
          file_bytes[cut] = file_bytes[cut] ^ (8'd1 << $urandom_range(0, 7));
        end
        1: size = size - $urandom_range(1, 12);
        2: size = size + $urandom_range(1, 40);
        3: repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom));
        4: size = 32'hFFFF_FFFF;
        5: begin
          cut = $urandom_range(1, size - 1);
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        6: begin
          // noise, sometimes behind a valid form type
          file_bytes.delete();
          if ($urandom_range(0, 1) == 1) add_word(FormSfbk);
          repeat ($urandom_range(4, 20)) file_bytes.push_back(8'($urandom));
          size = $urandom_range(0, 24);
        end
        default: ;
      endcase
      run_file(size);
    end
    gaps_on = 1'b1;
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    clear_walk();
    bank_size = 32'd4;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_short_sizes();
    test_full_bank();
    test_list_faults();
    test_sub_faults();
    test_size_change();
    test_backpressure();
    test_random_banks();
    settle();
    if (bad_count == 0 && pending_results.size() == 0) begin
      $display("[riff_chunk_map_parser_top] OK");
    end else begin
      $display("[riff_chunk_map_parser_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rcmp_pkg.sv
rtl/core/rcmp_walk.sv
rtl/core/rcmp_res_buf.sv
rtl/core/riff_chunk_map_parser_top.sv
tb/testbench.sv
